### rtl/smbs_pkg.sv
package smbs_pkg;

	localparam int unsigned DIVIDER_BITS_DEF = 16;
	localparam int unsigned HALF_W           = 16;
	localparam int unsigned CFG_INDEX_W      = 2;
	localparam int unsigned CFG_DATA_W       = 16;
	localparam logic [HALF_W-1:0] HALF_RESET = 16'd4;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CLOCK_POLARITY = 2'd0,
		REG_CLOCK_PHASE    = 2'd1,
		REG_HALF_PERIOD    = 2'd2
	} reg_index_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_LEADIN = 3'd1,
		PH_SHIFT  = 3'd2,
		PH_SAMPLE = 3'd3,
		PH_WAIT   = 3'd4,
		PH_TAIL   = 3'd5
	} phase_t;

	typedef struct packed {
		logic              clock_polarity;
		logic              clock_phase;
		logic [HALF_W-1:0] half_period_ticks;
	} cfg_t;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] tx_byte;
		logic       frame_last;
		logic       miso_level;
	} item_t;

	typedef struct packed {
		logic       sclk_level;
		logic       mosi_level;
		logic       mosi_drive;
		logic       byte_ready;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       frame_done;
	} result_t;

endpackage

### rtl/smbs_in_if.sv
interface smbs_in_if;
	logic       valid;
	logic       ready;
	logic       byte_valid;
	logic [7:0] tx_byte;
	logic       frame_last;
	logic       miso_level;

	modport source (output valid, byte_valid, tx_byte, frame_last, miso_level, input ready);
	modport sink (input valid, byte_valid, tx_byte, frame_last, miso_level, output ready);
endinterface

### rtl/smbs_out_if.sv
interface smbs_out_if;
	logic       valid;
	logic       ready;
	logic       sclk_level;
	logic       mosi_level;
	logic       mosi_drive;
	logic       byte_ready;
	logic       rx_valid;
	logic [7:0] rx_byte;
	logic       frame_done;

	modport source (output valid, sclk_level, mosi_level, mosi_drive, byte_ready, rx_valid,
		rx_byte, frame_done, input ready);
	modport sink (input valid, sclk_level, mosi_level, mosi_drive, byte_ready, rx_valid,
		rx_byte, frame_done, output ready);
endinterface

### rtl/smbs_cfg_if.sv
interface smbs_cfg_if
	import smbs_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/spi_master_byte_shifter.sv
// SPI master shifter for all four SPI modes (clock polarity and phase). Every word on din is one
// base-clock tick (optional byte to send, last-of-frame mark, sampled MISO level) and yields
// exactly one word on dout with the pin levels after that tick and any received byte. A word can be
// taken every cycle: the tick is evaluated in a single pass and lands in the output register, and din
// stays ready while that register is empty or being emptied, so throughput
// is one tick per cycle and is limited only by the consumer on dout. Configuration writes on cfg
// are always accepted and should only be issued while no transfer is in progress.
module spi_master_byte_shifter
	import smbs_pkg::*;
#(
	parameter int unsigned DIVIDER_BITS = DIVIDER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	smbs_cfg_if.sink    cfg,
	smbs_in_if.sink     din,
	smbs_out_if.source  dout
);

	cfg_t    cfg_q;
	item_t   item;
	result_t res;
	result_t res_s1;
	logic    out_valid_q;
	logic    accept;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clock_polarity    <= 1'b0;
			cfg_q.clock_phase       <= 1'b0;
			cfg_q.half_period_ticks <= HALF_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CLOCK_POLARITY: cfg_q.clock_polarity    <= cfg.data[0];
				REG_CLOCK_PHASE:    cfg_q.clock_phase       <= cfg.data[0];
				REG_HALF_PERIOD:    cfg_q.half_period_ticks <= cfg.data[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	assign din.ready = !out_valid_q || dout.ready;
	assign accept    = din.valid && din.ready;

	assign item.byte_valid = din.byte_valid;
	assign item.tx_byte    = din.tx_byte;
	assign item.frame_last = din.frame_last;
	assign item.miso_level = din.miso_level;

	smbs_engine #(
		.DIVIDER_BITS(DIVIDER_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.cfg    (cfg_q),
		.item   (item),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (din.ready) begin
			out_valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	assign dout.valid      = out_valid_q;
	assign dout.sclk_level = res_s1.sclk_level;
	assign dout.mosi_level = res_s1.mosi_level;
	assign dout.mosi_drive = res_s1.mosi_drive;
	assign dout.byte_ready = res_s1.byte_ready;
	assign dout.rx_valid   = res_s1.rx_valid;
	assign dout.rx_byte    = res_s1.rx_byte;
	assign dout.frame_done = res_s1.frame_done;

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> dout.valid)
		else $error("accepted tick did not produce an output word");

	a_done_releases: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res.frame_done) |-> !res.mosi_drive)
		else $error("MOSI still driven when the frame ends");

	a_no_take_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !(res.frame_done && res.byte_ready))
		else $error("byte taken on the tick that ends the frame");

	a_rx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && !dout.rx_valid) |-> (dout.rx_byte == 8'd0))
		else $error("received byte reported without rx_valid");

endmodule

### rtl/smbs_engine.sv
module smbs_engine
	import smbs_pkg::*;
#(
	parameter int unsigned DIVIDER_BITS = DIVIDER_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  cfg_t    cfg,
	input  item_t   item,
	output result_t res
);

	localparam int unsigned CW = (DIVIDER_BITS > HALF_W) ? DIVIDER_BITS : HALF_W;

	phase_t                  phase_q, phase_d;
	logic [2:0]              bit_index_q, bit_index_d;
	logic [DIVIDER_BITS-1:0] half_count_q, half_count_d;
	logic                    second_half_q, second_half_d;
	logic [7:0]              tx_shift_q, tx_shift_d;
	logic [7:0]              rx_shift_q, rx_shift_d;
	logic                    last_pending_q, last_pending_d;
	logic                    sclk_q, sclk_d;
	logic                    mosi_q, mosi_d;
	logic                    drive_q, drive_d;

	logic [HALF_W-1:0]       half_ticks;
	logic [DIVIDER_BITS-1:0] count_next;
	logic                    half_end;
	logic                    rx_done;
	logic                    start_shift;

	// A programmed half period of zero behaves as a single tick.
	assign half_ticks = (cfg.half_period_ticks == '0) ? HALF_W'(1) : cfg.half_period_ticks;
	assign count_next = half_count_q + DIVIDER_BITS'(1);
	assign half_end   = !((CW'(count_next) < CW'(half_ticks)) && (count_next != '0));
	assign rx_done    = (phase_q == PH_SAMPLE) && half_end && (bit_index_q == 3'd0);

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_IDLE: begin
				if (item.byte_valid) begin
					phase_d = cfg.clock_phase ? PH_LEADIN : PH_SHIFT;
				end
			end
			PH_WAIT: begin
				if (item.byte_valid) begin
					phase_d = PH_SHIFT;
				end
			end
			PH_LEADIN: begin
				if (half_end) begin
					phase_d = PH_SHIFT;
				end
			end
			PH_SHIFT: begin
				if (half_end) begin
					phase_d = PH_SAMPLE;
				end
			end
			PH_SAMPLE: begin
				if (half_end) begin
					if (bit_index_q != 3'd0) begin
						phase_d = PH_SHIFT;
					end else if (last_pending_q) begin
						phase_d = PH_TAIL;
					end else if (item.byte_valid) begin
						phase_d = PH_SHIFT;
					end else begin
						phase_d = PH_WAIT;
					end
				end
			end
			PH_TAIL: begin
				if (half_end && second_half_q) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				if (half_end) begin
					phase_d = PH_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		bit_index_d    = bit_index_q;
		half_count_d   = half_count_q;
		second_half_d  = second_half_q;
		tx_shift_d     = tx_shift_q;
		rx_shift_d     = rx_shift_q;
		last_pending_d = last_pending_q;
		sclk_d         = sclk_q;
		mosi_d         = mosi_q;
		drive_d        = drive_q;
		start_shift    = 1'b0;
		res            = '0;

		case (phase_q)
			PH_IDLE, PH_WAIT: begin
				if (item.byte_valid) begin
					res.byte_ready = 1'b1;
					tx_shift_d     = item.tx_byte;
					rx_shift_d     = '0;
					last_pending_d = item.frame_last;
					bit_index_d    = 3'd7;
					if (phase_q == PH_IDLE && cfg.clock_phase) begin
						half_count_d = '0;
						sclk_d       = cfg.clock_polarity;
					end else begin
						start_shift = 1'b1;
					end
				end
			end
			default: begin
				if (!half_end) begin
					half_count_d = count_next;
				end else begin
					half_count_d = '0;
					case (phase_q)
						PH_LEADIN: start_shift = 1'b1;
						PH_SHIFT: begin
							sclk_d     = cfg.clock_phase ? cfg.clock_polarity
								: !cfg.clock_polarity;
							rx_shift_d = {rx_shift_q[6:0], item.miso_level};
						end
						PH_SAMPLE: begin
							if (bit_index_q != 3'd0) begin
								bit_index_d = bit_index_q - 3'd1;
								start_shift = 1'b1;
							end else if (last_pending_q) begin
								sclk_d        = cfg.clock_polarity;
								drive_d       = 1'b0;
								second_half_d = cfg.clock_phase;
							end else if (item.byte_valid) begin
								res.byte_ready = 1'b1;
								tx_shift_d     = item.tx_byte;
								rx_shift_d     = '0;
								last_pending_d = item.frame_last;
								bit_index_d    = 3'd7;
								start_shift    = 1'b1;
							end else begin
								sclk_d = cfg.clock_polarity;
							end
						end
						PH_TAIL: begin
							if (!second_half_q) begin
								second_half_d = 1'b1;
							end else begin
								second_half_d  = 1'b0;
								last_pending_d = 1'b0;
								res.frame_done = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
		endcase

		// Entering a shifting half: MOSI takes the next bit of the word.
		if (start_shift) begin
			half_count_d = '0;
			sclk_d       = cfg.clock_phase ? !cfg.clock_polarity : cfg.clock_polarity;
			mosi_d       = tx_shift_d[bit_index_d];
			drive_d      = 1'b1;
		end

		res.rx_valid   = rx_done;
		res.rx_byte    = rx_done ? rx_shift_q : 8'd0;
		res.sclk_level = sclk_d;
		res.mosi_level = mosi_d;
		res.mosi_drive = drive_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			bit_index_q    <= 3'd7;
			half_count_q   <= '0;
			second_half_q  <= 1'b0;
			tx_shift_q     <= '0;
			rx_shift_q     <= '0;
			last_pending_q <= 1'b0;
			sclk_q         <= 1'b0;
			mosi_q         <= 1'b0;
			drive_q        <= 1'b0;
		end else if (step) begin
			phase_q        <= phase_d;
			bit_index_q    <= bit_index_d;
			half_count_q   <= half_count_d;
			second_half_q  <= second_half_d;
			tx_shift_q     <= tx_shift_d;
			rx_shift_q     <= rx_shift_d;
			last_pending_q <= last_pending_d;
			sclk_q         <= sclk_d;
			mosi_q         <= mosi_d;
			drive_q        <= drive_d;
		end
	end

endmodule
